@@ rtl/core/rc_servo_step_follower_assert.svh @@
// Assertion macros for the servo step follower checker.
`ifndef RC_SERVO_STEP_FOLLOWER_ASSERT_SVH
`define RC_SERVO_STEP_FOLLOWER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define RCSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rcsf_pkg.sv @@
package rcsf_pkg;

  // op codes
  localparam logic [1:0] OP_SET_RATE = 2'd0;
  localparam logic [1:0] OP_MOVE     = 2'd1;
  localparam logic [1:0] OP_ENABLE   = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_DEG_PER_STEP = 2'd0;
  localparam logic [1:0] CFG_BACKLASH     = 2'd1;
  localparam logic [1:0] CFG_REVERSE      = 2'd2;

  localparam logic [31:0] DEG_RESET   = 32'd16777;
  localparam logic [31:0] MIN_MAG     = 32'd505;
  localparam logic [40:0] PERIOD_NUM  = 41'd1048576000000;
  localparam logic [31:0] CENTRE_Q24  = 32'd1509949440;  // 90 deg in Q24
  localparam logic [31:0] HALF_Q24    = 32'd8388608;
  localparam logic [7:0]  ANGLE_MAX   = 8'd180;
  localparam logic [7:0]  ANGLE_MID   = 8'd90;

  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned MUL_STEPS = 32;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
    logic        sub;
  } alu_req_t;

endpackage

@@ rtl/core/rcsf_in_if.sv @@
interface rcsf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] rate;
  logic               in_backlash;
  logic               synced;
  logic [31:0]        now_ms;
  logic               enable_value;

  modport source (output valid, op, rate, in_backlash, synced, now_ms, enable_value,
                  input ready);
  modport sink (input valid, op, rate, in_backlash, synced, now_ms, enable_value,
                output ready);
endinterface

@@ rtl/core/rcsf_out_if.sv @@
interface rcsf_out_if;
  logic               valid;
  logic               ready;
  logic               angle_valid;
  logic [7:0]         servo_angle;
  logic               period_valid;
  logic [30:0]        step_period;
  logic signed [1:0]  direction;
  logic signed [31:0] position;

  modport source (output valid, angle_valid, servo_angle, period_valid, step_period,
                  direction, position, input ready);
  modport sink (input valid, angle_valid, servo_angle, period_valid, step_period,
                direction, position, output ready);
endinterface

@@ rtl/core/rcsf_cfg_if.sv @@
interface rcsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rcsf_addsub.sv @@
module rcsf_addsub import rcsf_pkg::*; (
  input  alu_req_t    req,
  output logic [33:0] res
);
  // bit 33 is carry on add, borrow on subtract
  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
  end
endmodule

@@ rtl/core/rc_servo_step_follower.sv @@
// Processing: set_rate may run a restoring divide (31 divider steps), a move tick
//   a shift-add multiply (32 multiplier steps), enable/disable neither; plus output stall.
// Throughput: one beat at a time; the next input beat is taken once the shared
//   33-bit add/subtract unit and sequencer are back in idle.
// Reset: rst_n synchronous, active low; control state and configuration to defaults, payload and datapath not reset.
module rc_servo_step_follower import rcsf_pkg::*; #(
  parameter int unsigned THROTTLE_MS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  rcsf_in_if.sink     in_bus,
  rcsf_out_if.source  out_bus,
  rcsf_cfg_if.sink    cfg_bus
);

  localparam logic [31:0] ThrottleW = 32'(THROTTLE_MS);
  localparam logic [4:0]  DivLast   = 5'(DIV_STEPS - 1);
  localparam logic [4:0]  MulLast   = 5'(MUL_STEPS - 1);

  // sequencer
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,  // decode and direct register updates
    S_DIV   = 8'b0000_0100,  // restoring divide, one quotient bit per cycle
    S_PFIN  = 8'b0000_1000,  // compare new period against programmed one
    S_APREP = 8'b0001_0000,  // sign handling before angle multiply
    S_MUL   = 8'b0010_0000,  // shift-add multiply, one bit per cycle
    S_ANG   = 8'b0100_0000,  // centre, clamp, round
    S_EMIT  = 8'b1000_0000   // park result until output slot frees
  } state_t;

  state_t state_r, state_nxt;

  // captured input beat
  logic [1:0]  op_r;
  logic [31:0] rate_r;
  logic        bl_r, sy_r, ev_r;
  logic [31:0] now_r;

  // configuration
  logic [31:0] deg_r;
  logic [30:0] backlash_r;
  logic        reverse_r;

  // block state
  logic              enabled_r, enabled_nxt;
  logic signed [1:0] step_dir_r, step_dir_nxt;
  logic [31:0]       last_rate_r, last_rate_nxt;
  logic [31:0]       target_r, target_nxt;
  logic [31:0]       motor_r, motor_nxt;
  logic [31:0]       last_upd_r, last_upd_nxt;
  logic [30:0]       pp_r, pp_nxt;

  // datapath of the shared unit
  logic [31:0] mag_r, mag_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] sh_r, sh_nxt;     // dividend bits in, quotient bits out
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;     // multiplier in, product low half out
  logic        neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  // pending result
  logic        res_av_r, res_av_nxt;
  logic [7:0]  res_ang_r, res_ang_nxt;
  logic        res_pv_r, res_pv_nxt;
  logic [30:0] res_per_r, res_per_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic              o_av_r, o_pv_r;
  logic [7:0]        o_ang_r;
  logic [30:0]       o_per_r;
  logic signed [1:0] o_dir_r;
  logic [31:0]       o_pos_r;
  logic              out_load;

  alu_req_t    alu_req;
  logic [33:0] alu_res;

  rcsf_addsub u_alu (.req(alu_req), .res(alu_res));

  // combinational helpers for EXEC and the final stages
  logic [31:0]       abs_rate, mag_c, tgt_c, elapsed, p_c, v_c, vr_c;
  logic [40:0]       num_c;
  logic signed [1:0] dir_c;
  logic              big_c;
  logic [7:0]        ang_c;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid        = ov_r;
  assign out_bus.angle_valid  = o_av_r;
  assign out_bus.servo_angle  = o_ang_r;
  assign out_bus.period_valid = o_pv_r;
  assign out_bus.step_period  = o_per_r;
  assign out_bus.direction    = o_dir_r;
  assign out_bus.position     = o_pos_r;

  // shared unit: subtract for the divider, add for the multiplier
  always_comb begin
    alu_req = '0;
    if (state_r == S_DIV) begin
      alu_req.a   = {rem_r, sh_r[30]};
      alu_req.b   = {1'b0, mag_r};
      alu_req.sub = 1'b1;
    end else if (state_r == S_MUL) begin
      alu_req.a   = {1'b0, hi_r};
      alu_req.b   = lo_r[0] ? {1'b0, deg_r} : 33'd0;
      alu_req.sub = 1'b0;
    end
  end

  always_comb begin
    // rate magnitude; -2^31 comes out as 2^31 unsigned
    abs_rate = rate_r[31] ? (32'd0 - rate_r) : rate_r;
    if (rate_r == 32'd0) begin
      dir_c = 2'sd0;
    end else if (rate_r[31]) begin
      dir_c = -2'sd1;
    end else begin
      dir_c = 2'sd1;
    end
    mag_c = bl_r ? {1'b0, backlash_r} : abs_rate;
    if (mag_c < MIN_MAG) begin
      dir_c = 2'sd0;
    end
    num_c = PERIOD_NUM + {10'd0, mag_c[31:1]};

    // target advance on a synced tick outside backlash
    tgt_c = (sy_r && !bl_r) ? (target_r + {{30{step_dir_r[1]}}, step_dir_r}) : target_r;
    elapsed = now_r - last_upd_r;

    p_c = reverse_r ? (32'd0 - motor_r) : motor_r;

    // angle from product; a product under the centre fits in lo_r
    big_c = (hi_r != 32'd0) || (lo_r >= CENTRE_Q24);
    v_c   = neg_r ? (CENTRE_Q24 - lo_r) : (CENTRE_Q24 + lo_r);
    vr_c  = v_c + HALF_Q24;
    if (big_c) begin
      ang_c = neg_r ? 8'd0 : ANGLE_MAX;
    end else if (vr_c[31:24] > ANGLE_MAX) begin
      ang_c = ANGLE_MAX;
    end else begin
      ang_c = vr_c[31:24];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    enabled_nxt   = enabled_r;
    step_dir_nxt  = step_dir_r;
    last_rate_nxt = last_rate_r;
    target_nxt    = target_r;
    motor_nxt     = motor_r;
    last_upd_nxt  = last_upd_r;
    pp_nxt        = pp_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    res_av_nxt    = res_av_r;
    res_ang_nxt   = res_ang_r;
    res_pv_nxt    = res_pv_r;
    res_per_nxt   = res_per_r;
    out_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_SET_RATE: begin
            if (!enabled_r) begin
              res_av_nxt  = 1'b0;
              res_ang_nxt = 8'd0;
              res_pv_nxt  = 1'b1;
              res_per_nxt = 31'd0;
              state_nxt   = S_EMIT;
            end else begin
              step_dir_nxt = dir_c;
              if (mag_c != last_rate_r) begin
                last_rate_nxt = mag_c;
                mag_nxt       = mag_c;
                cnt_nxt       = 5'd0;
                if (mag_c >= MIN_MAG) begin
                  rem_nxt   = {22'd0, num_c[40:31]};
                  sh_nxt    = num_c[30:0];
                  state_nxt = S_DIV;
                end else begin
                  sh_nxt    = 31'd0;
                  state_nxt = S_PFIN;
                end
              end
            end
          end
          OP_MOVE: begin
            target_nxt = tgt_c;
            if ($signed(motor_r) != $signed(tgt_c)) begin
              motor_nxt = ($signed(motor_r) > $signed(tgt_c)) ? (motor_r - 32'd1)
                                                                : (motor_r + 32'd1);
              if (elapsed >= ThrottleW) begin
                last_upd_nxt = now_r;
                state_nxt    = S_APREP;
              end
            end
          end
          OP_ENABLE: begin
            enabled_nxt = ev_r;
            if (!ev_r) begin
              pp_nxt       = 31'd0;
              step_dir_nxt = 2'sd0;
              res_av_nxt   = 1'b1;
              res_ang_nxt  = ANGLE_MID;
              res_pv_nxt   = 1'b1;
              res_per_nxt  = 31'd0;
              state_nxt    = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_DIV: begin
        if (!alu_res[33]) begin
          rem_nxt = alu_res[31:0];
          sh_nxt  = {sh_r[29:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], sh_r[30]};
          sh_nxt  = {sh_r[29:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DivLast) begin
          state_nxt = S_PFIN;
        end
      end

      S_PFIN: begin
        if (sh_r != pp_r) begin
          pp_nxt      = sh_r;
          res_av_nxt  = 1'b0;
          res_ang_nxt = 8'd0;
          res_pv_nxt  = 1'b1;
          res_per_nxt = sh_r;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_APREP: begin
        neg_nxt   = p_c[31];
        lo_nxt    = p_c[31] ? (32'd0 - p_c) : p_c;
        hi_nxt    = 32'd0;
        cnt_nxt   = 5'd0;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        hi_nxt  = alu_res[32:1];
        lo_nxt  = {alu_res[0], lo_r[31:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MulLast) begin
          state_nxt = S_ANG;
        end
      end

      S_ANG: begin
        res_av_nxt  = 1'b1;
        res_ang_nxt = ang_c;
        res_pv_nxt  = 1'b0;
        res_per_nxt = 31'd0;
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (!ov_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_bus.ready) begin
      ov_nxt = 1'b0;
    end
    if (out_load) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      deg_r       <= DEG_RESET;
      backlash_r  <= 31'd0;
      reverse_r   <= 1'b0;
      enabled_r   <= 1'b0;
      step_dir_r  <= 2'sd0;
      last_rate_r <= 32'd0;
      target_r    <= 32'd0;
      motor_r     <= 32'd0;
      last_upd_r  <= 32'd0;
      pp_r        <= 31'd0;
      cnt_r       <= 5'd0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enabled_r   <= enabled_nxt;
      step_dir_r  <= step_dir_nxt;
      last_rate_r <= last_rate_nxt;
      target_r    <= target_nxt;
      motor_r     <= motor_nxt;
      last_upd_r  <= last_upd_nxt;
      pp_r        <= pp_nxt;
      cnt_r       <= cnt_nxt;
      ov_r        <= ov_nxt;
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          CFG_DEG_PER_STEP: deg_r      <= cfg_bus.data;
          CFG_BACKLASH:     backlash_r <= cfg_bus.data[30:0];
          CFG_REVERSE:      reverse_r  <= cfg_bus.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_bus.valid && (state_r == S_IDLE)) begin
      op_r   <= in_bus.op;
      rate_r <= in_bus.rate;
      bl_r   <= in_bus.in_backlash;
      sy_r   <= in_bus.synced;
      now_r  <= in_bus.now_ms;
      ev_r   <= in_bus.enable_value;
    end
    mag_r     <= mag_nxt;
    rem_r     <= rem_nxt;
    sh_r      <= sh_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    neg_r     <= neg_nxt;
    res_av_r  <= res_av_nxt;
    res_ang_r <= res_ang_nxt;
    res_pv_r  <= res_pv_nxt;
    res_per_r <= res_per_nxt;
    if (out_load) begin
      o_av_r  <= res_av_r;
      o_ang_r <= res_ang_r;
      o_pv_r  <= res_pv_r;
      o_per_r <= res_per_r;
      o_dir_r <= step_dir_r;
      o_pos_r <= motor_r;
    end
  end

endmodule

@@ rtl/core/rcsf_checker.sv @@
`include "rc_servo_step_follower_assert.svh"

module rcsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        angle_valid,
  input logic [7:0]  servo_angle,
  input logic        period_valid,
  input logic [30:0] step_period,
  input logic [1:0]  direction,
  input logic [31:0] position
);

  // stalled beat holds
  `RCSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(servo_angle) && $stable(step_period) && $stable(position) && $stable(direction), "stalled output beat changed")

  // one item in flight: no back-to-back accept
  `RCSF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input accepted while busy")

  `RCSF_ASSERT_NOW(a_angle_range, out_valid, (servo_angle <= 8'd180) && (angle_valid || (servo_angle == 8'd0)), "servo angle out of range or stale")

  `RCSF_ASSERT_NOW(a_period_zero, out_valid && !period_valid, step_period == 31'd0, "step period set without period_valid")

  `RCSF_ASSERT_NOW(a_dir_code, out_valid, direction != 2'b10, "illegal direction code")

endmodule

bind rc_servo_step_follower rcsf_checker u_rcsf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .angle_valid  (out_bus.angle_valid),
  .servo_angle  (out_bus.servo_angle),
  .period_valid (out_bus.period_valid),
  .step_period  (out_bus.step_period),
  .direction    (out_bus.direction),
  .position     (out_bus.position)
);

@@ tb/rcsf_servo_cmd_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the servo step follower, keeps its own copy of
// the follower state and registers, predicts each servo command and compares
// accepted output beats against the oldest prediction.
module rcsf_servo_cmd_checker import rcsf_pkg::*; #(
  parameter int unsigned THROTTLE_MS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  rcsf_in_if          in_mon,
  rcsf_out_if         out_mon,
  rcsf_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam logic [63:0] STEP_PERIOD_NUM = 64'd1048576000000;
  localparam logic [31:0] RATE_FLOOR      = 32'd505;
  localparam logic [63:0] MID_Q24         = 64'd90 << 24;
  localparam logic [63:0] ROUND_Q24       = 64'd1 << 23;

  typedef struct packed {
    logic              angle_valid;
    logic [7:0]        servo_angle;
    logic              period_valid;
    logic [30:0]       step_period;
    logic signed [1:0] direction;
    logic [31:0]       position;
  } servo_cmd_t;

  servo_cmd_t servo_cmd_q[$];

  // register copies
  logic [31:0] deg_q24;
  logic [30:0] backlash_mag;
  logic        reverse;

  // follower state
  logic              enabled;
  logic signed [1:0] step_dir;
  logic [31:0]       last_mag;
  logic [31:0]       target_pos;
  logic [31:0]       motor_pos;
  logic [31:0]       last_emit_ms;
  logic [31:0]       period_prog;

  int unsigned mismatches = 0;

  function automatic void queue_cmd(logic av, logic [7:0] ang, logic pv, logic [30:0] per);
    servo_cmd_t c;
    c.angle_valid  = av;
    c.servo_angle  = ang;
    c.period_valid = pv;
    c.step_period  = per;
    c.direction    = step_dir;
    c.position     = motor_pos;
    servo_cmd_q.push_back(c);
  endfunction

  function automatic logic [7:0] servo_angle_for(logic [31:0] pos);
    logic [31:0] p;
    logic [31:0] m;
    logic        neg;
    logic [63:0] swing;
    logic [63:0] v;
    p     = reverse ? (32'd0 - pos) : pos;
    neg   = p[31];
    m     = neg ? (32'd0 - p) : p;
    swing = {32'd0, m} * {32'd0, deg_q24};
    if (swing >= MID_Q24) return neg ? 8'd0 : 8'd180;
    v = neg ? (MID_Q24 - swing) : (MID_Q24 + swing);
    v = (v + ROUND_Q24) >> 24;
    return (v > 64'd180) ? 8'd180 : v[7:0];
  endfunction

  function automatic void apply_set_rate(logic [31:0] rate, logic bl);
    logic signed [1:0] dir;
    logic [31:0]       mag;
    logic [63:0]       quot;
    logic [31:0]       per;
    if (!enabled) begin
      queue_cmd(1'b0, 8'd0, 1'b1, 31'd0);
      return;
    end
    if (rate == 32'd0) begin
      dir = 2'sd0;
      mag = 32'd0;
    end else if (rate[31]) begin
      dir = -2'sd1;
      mag = 32'd0 - rate;  // -2^31 comes out as 2^31
    end else begin
      dir = 2'sd1;
      mag = rate;
    end
    if (bl) mag = {1'b0, backlash_mag};
    if (mag < RATE_FLOOR) dir = 2'sd0;
    step_dir = dir;
    if (mag == last_mag) return;
    last_mag = mag;
    per = 32'd0;
    if (mag >= RATE_FLOOR) begin
      quot = (STEP_PERIOD_NUM + {33'd0, mag[31:1]}) / {32'd0, mag};
      per  = quot[31:0];
    end
    if (per != period_prog) begin
      period_prog = per;
      queue_cmd(1'b0, 8'd0, 1'b1, per[30:0]);
    end
  endfunction

  function automatic void apply_move_tick(logic bl, logic sy, logic [31:0] now);
    logic [31:0] since;
    if (sy && !bl) target_pos = target_pos + {{30{step_dir[1]}}, step_dir};
    if ($signed(motor_pos) > $signed(target_pos)) motor_pos = motor_pos - 32'd1;
    else if ($signed(motor_pos) < $signed(target_pos)) motor_pos = motor_pos + 32'd1;
    else return;
    since = now - last_emit_ms;
    if (since < THROTTLE_MS) return;
    last_emit_ms = now;
    queue_cmd(1'b1, servo_angle_for(motor_pos), 1'b0, 31'd0);
  endfunction

  function automatic void apply_enable(logic ev);
    enabled = ev;
    if (ev) return;
    period_prog = 32'd0;
    step_dir    = 2'sd0;
    queue_cmd(1'b1, 8'd90, 1'b1, 31'd0);
  endfunction

  function automatic int unsigned field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    servo_cmd_t want;
    if (!rst_n) begin
      deg_q24      = 32'd16777;
      backlash_mag = 31'd0;
      reverse      = 1'b0;
      enabled      = 1'b0;
      step_dir     = 2'sd0;
      last_mag     = 32'd0;
      target_pos   = 32'd0;
      motor_pos    = 32'd0;
      last_emit_ms = 32'd0;
      period_prog  = 32'd0;
      servo_cmd_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DEG_PER_STEP: deg_q24 = cfg_mon.data;
          CFG_BACKLASH:     backlash_mag = cfg_mon.data[30:0];
          CFG_REVERSE:      reverse = cfg_mon.data[0];
          default: ;
        endcase
      end
      // results always trail their input beat, so pop before push
      if (out_mon.valid && out_mon.ready) begin
        if (servo_cmd_q.size() == 0) begin
          $display("%0t: unexpected output beat, angle %0d period %0d", $time,
                   out_mon.servo_angle, out_mon.step_period);
          mismatches++;
        end else begin
          want = servo_cmd_q.pop_front();
          mismatches += field_diff("angle_valid", {31'd0, want.angle_valid},
                                   {31'd0, out_mon.angle_valid});
          mismatches += field_diff("servo_angle", {24'd0, want.servo_angle},
                                   {24'd0, out_mon.servo_angle});
          mismatches += field_diff("period_valid", {31'd0, want.period_valid},
                                   {31'd0, out_mon.period_valid});
          mismatches += field_diff("step_period", {1'b0, want.step_period},
                                   {1'b0, out_mon.step_period});
          mismatches += field_diff("direction", {30'd0, want.direction},
                                   {30'd0, out_mon.direction});
          mismatches += field_diff("position", want.position, out_mon.position);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_SET_RATE: apply_set_rate(in_mon.rate, in_mon.in_backlash);
          OP_MOVE:     apply_move_tick(in_mon.in_backlash, in_mon.synced, in_mon.now_ms);
          OP_ENABLE:   apply_enable(in_mon.enable_value);
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= servo_cmd_q.size();
  end

endmodule

@@ tb/tb_rc_servo_step_follower.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the servo step follower. The checker instance does
// all prediction and comparison; this module only drives beats, throttles the
// output side and decides pass/fail.
module tb_rc_servo_step_follower;
  import rcsf_pkg::*;

  localparam int unsigned THROTTLE_MS  = 20;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;   // decoded as a no-op
  localparam int          DRAIN_CYCLES = 64;     // worst case latency plus margin
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_BEATS  = 150;
  localparam int          CYCLE_LIMIT  = 600000;

  // rates sitting on the interesting boundaries: floor, sign, full scale
  localparam logic [31:0] CORNER_RATES [8] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0001,
    32'hFFFF_FFFF, 32'd505, 32'hFFFF_FE07, 32'd504
  };

  logic clk = 1'b0;
  logic rst_n;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;

  // idle knobs, changed by the stimulus per phase
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_run = 0;

  logic [31:0] clock_ms;   // free running ms time carried by move ticks
  logic [31:0] last_rate;

  rcsf_in_if  in_bus ();
  rcsf_out_if out_bus ();
  rcsf_cfg_if cfg_bus ();

  rc_servo_step_follower #(.THROTTLE_MS(THROTTLE_MS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  rcsf_servo_cmd_checker #(.THROTTLE_MS(THROTTLE_MS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output backpressure: random stall bursts at a per-phase rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_run != 0) begin
      out_bus.ready <= 1'b0;
      stall_run     <= stall_run - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_bus.ready <= 1'b0;
      stall_run     <= $urandom_range(0, 10);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("[rc_servo_step_follower] ERROR");
    $finish;
  end

  // One input beat. valid stays up afterwards unless a gap burst is taken, so
  // back-to-back beats never see valid dropped and raised in the same step.
  task automatic send_beat(input logic [1:0] op, input logic [31:0] rate,
                           input logic bl, input logic sy,
                           input logic [31:0] now, input logic ev);
    in_bus.valid        <= 1'b1;
    in_bus.op           <= op;
    in_bus.rate         <= rate;
    in_bus.in_backlash  <= bl;
    in_bus.synced       <= sy;
    in_bus.now_ms       <= now;
    in_bus.enable_value <= ev;
    do @(posedge clk); while (!in_bus.ready);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted command is out, then let any
  // no-result beat still in the datapath finish.
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          beats;
    int          pick;
    int          signed_val;
    logic [1:0]  op;
    logic [31:0] rate;
    logic        bl;
    logic        sy;
    logic        ev;
    logic [31:0] deg_val;
    logic [31:0] bl_val;
    logic        rev_val;

    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.op           <= OP_SET_RATE;
    in_bus.rate         <= '0;
    in_bus.in_backlash  <= 1'b0;
    in_bus.synced       <= 1'b0;
    in_bus.now_ms       <= '0;
    in_bus.enable_value <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_DEG_PER_STEP;
    cfg_bus.data        <= '0;
    clock_ms  = 32'd0;
    last_rate = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset registers, no idling ----
    // set_rate while disabled answers period 0, state untouched
    send_beat(OP_SET_RATE, 32'd1000, 1'b0, 1'b0, 32'd0, 1'b0);
    // move tick with motor already at target: silent
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b0, 32'd5, 1'b0);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
    send_beat(OP_ENABLE, 32'd0, 1'b0, 1'b0, 32'd0, 1'b1);
    // full scale both signs; -2^31 treated as magnitude 2^31
    send_beat(OP_SET_RATE, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_SET_RATE, 32'h8000_0000, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_SET_RATE, 32'h8000_0001, 1'b0, 1'b0, 32'd0, 1'b0);
    // just below the floor: period 0, direction 0; then the repeat with other sign
    send_beat(OP_SET_RATE, 32'd504, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_SET_RATE, 32'hFFFF_FE08, 1'b0, 1'b0, 32'd0, 1'b0);
    // floor itself: longest period
    send_beat(OP_SET_RATE, 32'd505, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_SET_RATE, 32'd65536, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_SET_RATE, 32'd65536, 1'b0, 1'b0, 32'd0, 1'b0);
    // throttle: 20 ms emits, 19 ms holds, 20 again emits
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b1, 32'd20, 1'b0);
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b1, 32'd39, 1'b0);
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b1, 32'd40, 1'b0);
    // backlash rate (0 after reset) overrides the commanded magnitude
    send_beat(OP_SET_RATE, 32'hFFFF_0000, 1'b1, 1'b0, 32'd0, 1'b0);
    send_beat(OP_MOVE, 32'd0, 1'b1, 1'b1, 32'd80, 1'b0);
    send_beat(OP_SET_RATE, 32'hFFFF_0000, 1'b0, 1'b0, 32'd0, 1'b0);
    // time wrapping through 2^32
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b1, 32'hFFFF_FFF0, 1'b0);
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b1, 32'h0000_0004, 1'b0);
    send_beat(OP_MOVE, 32'd0, 1'b0, 1'b0, 32'h0000_0030, 1'b0);
    // disable centers the servo; set_rate with zero rate while off
    send_beat(OP_ENABLE, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_SET_RATE, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0);
    send_beat(OP_ENABLE, 32'd0, 1'b0, 1'b0, 32'd0, 1'b1);
    send_beat(OP_SET_RATE, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0);
    clock_ms = 32'h0000_0030;

    // ---- random phases, registers rewritten between them ----
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin deg_val = 32'hFFFF_FFFF; bl_val = 32'h7FFF_FFFF; rev_val = 1'b1; end
        1: begin deg_val = 32'd0;         bl_val = 32'd0;         rev_val = 1'b0; end
        2: begin deg_val = 32'h0100_0000; bl_val = 32'd504;       rev_val = 1'b0; end
        3: begin deg_val = 32'h0040_0000; bl_val = 32'd505;       rev_val = 1'b1; end
        default: begin
          deg_val = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0200_0000);
          bl_val  = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000);
          rev_val = $urandom_range(0, 1);
        end
      endcase
      write_reg(CFG_DEG_PER_STEP, deg_val);
      write_reg(CFG_BACKLASH, bl_val);          // bit 31 is don't-care
      write_reg(CFG_REVERSE, ($urandom() & 32'hFFFF_FFFE) | {31'd0, rev_val});

      // last phase runs flat out; the others mix gaps, stalls and quiet stretches
      if (phase == NUM_PHASES - 1) begin
        gap_pct   <= 0;
        stall_pct <= 0;
      end else begin
        gap_pct   <= (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 35);
        stall_pct <= (phase % 4 == 2) ? 0 : ((phase % 2 == 0) ? 8 : 30);
      end

      beats = 0;
      while (beats < PHASE_BEATS) begin
        // every field random by default; the op decides what matters
        rate = $urandom();
        bl   = ($urandom_range(0, 99) < 15);
        sy   = ($urandom_range(0, 99) < 80);
        ev   = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          op = OP_SET_RATE;
          case ($urandom_range(0, 5))
            0: ;  // keep the raw random rate
            1: begin
              signed_val = int'($urandom_range(0, 1100)) - 550;
              rate = signed_val;
            end
            2: begin
              signed_val = int'($urandom_range(1, 3000)) * 65536;
              rate = ($urandom_range(0, 1) == 0) ? signed_val : -signed_val;
            end
            3: rate = CORNER_RATES[$urandom_range(0, 7)];
            4: rate = last_rate;              // repeated magnitude
            default: rate = 32'd0 - last_rate; // same magnitude, flipped sign
          endcase
          last_rate = rate;
        end else if (pick < 15) begin
          op = OP_ENABLE;
          ev = ($urandom_range(0, 99) < 70);
        end else if (pick < 17) begin
          op = OP_UNUSED;
        end else begin
          op = OP_MOVE;
          clock_ms += ($urandom_range(0, 99) < 3) ? $urandom() : $urandom_range(0, 25);
        end
        send_beat(op, rate, bl, sy, (op == OP_MOVE) ? clock_ms : $urandom(), ev);
        if (op != OP_UNUSED) beats++;
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[rc_servo_step_follower] OK");
    end else begin
      $display("[rc_servo_step_follower] ERROR");
    end
    $finish;
  end

endmodule
